### sv/distance_vector_route_table_core_macros.svh
// Assertion macros for the route table checker.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_CORE_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DVRT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("route table check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define DVRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("route table check failed");

`endif

### sv/dvrt_pkg.sv
// Shared constants and opcodes of the distance-vector route table.
package dvrt_pkg;

  localparam int NODES_DEF     = 16;
  localparam int COST_BITS_DEF = 16;
  localparam int OP_BITS       = 2;

  localparam logic [OP_BITS-1:0] OP_LINK   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ADVERT = 2'd1;
  localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd2;
  localparam logic [OP_BITS-1:0] OP_RSVD   = 2'd3;

endpackage

### sv/dvrt_pair_mem.sv
// Pair memory: link costs on the diagonal, advertised costs elsewhere; two read ports.
module dvrt_pair_mem #(
  parameter int ADDR_BITS = 8,
  parameter int DATA_BITS = 17
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr_a,
  input  logic [ADDR_BITS-1:0] raddr_b,
  output logic [DATA_BITS-1:0] rdata_a,
  output logic [DATA_BITS-1:0] rdata_b
);

  logic [DATA_BITS-1:0] mem [1<<ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### sv/dvrt_route_mem.sv
// Route memory: valid bit, next hop and best cost per destination.
module dvrt_route_mem #(
  parameter int ADDR_BITS = 4,
  parameter int DATA_BITS = 21
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [1<<ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/distance_vector_route_table_core.sv
// Top level of the distance-vector route table: sequencer, scan datapath and result register.
//
// A word is taken when start is high and busy is low; results appear for one cycle each on
// route_strobe and cannot be held off, so the receiver must take every one. After reset the
// block sweeps both memories clear, one pair entry a cycle, with busy high. A lookup reads
// the route memory and then answers. An advertisement walks every neighbour once for its
// destination. A link update walks every neighbour for every destination and then checks
// the neighbour's own entry. The pair memory gives one link cost and one advertised cost
// per cycle to the scan. Each result is held back until the next is known, so that the
// final one can carry last; the neighbour's own new entry, created at the end of a link
// update, comes on the cycle after the result before it. Unknown opcodes and node numbers
// beyond the table are dropped with no result, except a lookup, which answers found low.
module distance_vector_route_table_core #(
  parameter  int NODES     = dvrt_pkg::NODES_DEF,
  parameter  int COST_BITS = dvrt_pkg::COST_BITS_DEF,
  localparam int NB        = $clog2(NODES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [dvrt_pkg::OP_BITS-1:0]  opcode,
  input  logic [NB-1:0]                 neighbor,
  input  logic [NB-1:0]                 dest,
  input  logic [COST_BITS-1:0]          cost,
  output logic                          route_strobe,
  output logic [NB-1:0]                 route_dest,
  output logic [COST_BITS-1:0]          route_cost,
  output logic [NB-1:0]                 next_hop,
  output logic                          found,
  output logic                          last
);
  import dvrt_pkg::*;

  localparam int PA_BITS = 2 * NB;
  localparam int PD_BITS = COST_BITS + 1;
  localparam int RD_BITS = COST_BITS + NB + 1;
  localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};
  localparam logic [NB:0]          NODES_W  = (NB+1)'(NODES);

  typedef enum logic [10:0] {
    S_CLEAR      = 11'b000_0000_0001,
    S_IDLE       = 11'b000_0000_0010,
    S_ROUTE_RD   = 11'b000_0000_0100,
    S_SCAN       = 11'b000_0000_1000,
    S_DRAIN      = 11'b000_0001_0000,
    S_DECIDE     = 11'b000_0010_0000,
    S_CREATE_RD  = 11'b000_0100_0000,
    S_CREATE     = 11'b000_1000_0000,
    S_LOOKUP_RD  = 11'b001_0000_0000,
    S_LOOKUP_OUT = 11'b010_0000_0000,
    S_FINISH     = 11'b100_0000_0000
  } state_t;

  state_t                 state;
  logic [PA_BITS-1:0]     clr;
  logic [OP_BITS-1:0]     op;
  logic [NB-1:0]          nb;
  logic [NB-1:0]          d;
  logic [COST_BITS-1:0]   cost_in;
  logic [NB-1:0]          i;
  logic                   s1_valid;
  logic                   s1_self;
  logic [NB-1:0]          s1_i;
  logic [COST_BITS-1:0]   best;
  logic [NB-1:0]          hop;
  logic                   any;
  logic                   pend_valid;
  logic [NB-1:0]          pend_dest;
  logic [COST_BITS-1:0]   pend_cost;
  logic [NB-1:0]          pend_hop;

  // Memory ports
  logic                   pw_en;
  logic [PA_BITS-1:0]     pw_addr;
  logic [PD_BITS-1:0]     pw_data;
  logic [PD_BITS-1:0]     pa_data;
  logic [PD_BITS-1:0]     pb_data;
  logic                   rw_en;
  logic [NB-1:0]          rw_addr;
  logic [RD_BITS-1:0]     rw_data;
  logic                   rr_en;
  logic [NB-1:0]          rr_addr;
  logic [RD_BITS-1:0]     rr_data;

  // Decode and datapath
  logic                   accept;
  logic                   nb_ok;
  logic                   d_ok;
  logic                   r_valid;
  logic [NB-1:0]          r_hop;
  logic [COST_BITS-1:0]   r_cost;
  logic                   cand_ok;
  logic [COST_BITS:0]     sum;
  logic [COST_BITS-1:0]   sat;
  logic                   take;
  logic                   upd;
  logic                   create;

  assign busy    = (state != S_IDLE);
  assign accept  = start && (state == S_IDLE);
  assign nb_ok   = {1'b0, neighbor} < NODES_W;
  assign d_ok    = {1'b0, dest} < NODES_W;
  assign r_valid = rr_data[RD_BITS-1];
  assign r_hop   = rr_data[COST_BITS +: NB];
  assign r_cost  = rr_data[COST_BITS-1:0];

  // Candidate through neighbour s1_i: link cost plus advertised cost, or the link alone
  // when the neighbour is the destination itself. Saturate at the unreachable mark.
  assign cand_ok = pa_data[COST_BITS] && (s1_self || pb_data[COST_BITS]);
  assign sum     = {1'b0, pa_data[COST_BITS-1:0]}
                 + {1'b0, (s1_self ? '0 : pb_data[COST_BITS-1:0])};
  assign sat     = sum[COST_BITS] ? COST_MAX : sum[COST_BITS-1:0];
  assign take    = s1_valid && cand_ok && (!any || (sat < best));

  // In S_DECIDE a link update changes only present entries; an advertisement may add one.
  assign upd     = (best != r_cost) && ((op == OP_ADVERT) || r_valid);
  assign create  = !r_valid;

  // Pair memory write: clearing sweep, or the incoming link / advertisement word.
  // An advertisement of a neighbour to itself is never used, so drop it.
  always_comb begin
    pw_en   = 1'b0;
    pw_addr = clr;
    pw_data = '0;
    if (state == S_CLEAR) begin
      pw_en = 1'b1;
    end else if (accept && nb_ok && (opcode == OP_LINK)) begin
      pw_en   = 1'b1;
      pw_addr = {neighbor, neighbor};
      pw_data = {1'b1, cost};
    end else if (accept && nb_ok && d_ok && (opcode == OP_ADVERT) && (neighbor != dest)) begin
      pw_en   = 1'b1;
      pw_addr = {neighbor, dest};
      pw_data = {1'b1, cost};
    end
  end

  // Route memory write: clearing sweep, recomputed entry, or new direct neighbour.
  always_comb begin
    rw_en   = 1'b0;
    rw_addr = clr[NB-1:0];
    rw_data = {1'b0, {NB{1'b0}}, COST_MAX};
    case (state)
      S_CLEAR: begin
        rw_en = 1'b1;
      end
      S_DECIDE: begin
        rw_en   = upd;
        rw_addr = d;
        rw_data = {1'b1, hop, best};
      end
      S_CREATE: begin
        rw_en   = create;
        rw_addr = nb;
        rw_data = {1'b1, nb, cost_in};
      end
      default: begin
        rw_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    rr_en   = 1'b0;
    rr_addr = d;
    case (state)
      S_ROUTE_RD:  rr_en = 1'b1;
      S_LOOKUP_RD: rr_en = 1'b1;
      S_CREATE_RD: begin
        rr_en   = 1'b1;
        rr_addr = nb;
      end
      default:     rr_en = 1'b0;
    endcase
  end

  dvrt_pair_mem #(
    .ADDR_BITS (PA_BITS),
    .DATA_BITS (PD_BITS)
  ) u_pair (
    .clk     (clk),
    .we      (pw_en),
    .waddr   (pw_addr),
    .wdata   (pw_data),
    .re      (state == S_SCAN),
    .raddr_a ({i, i}),
    .raddr_b ({i, d}),
    .rdata_a (pa_data),
    .rdata_b (pb_data)
  );

  dvrt_route_mem #(
    .ADDR_BITS (NB),
    .DATA_BITS (RD_BITS)
  ) u_route (
    .clk   (clk),
    .we    (rw_en),
    .waddr (rw_addr),
    .wdata (rw_data),
    .re    (rr_en),
    .raddr (rr_addr),
    .rdata (rr_data)
  );

  // Sequencer, scan accumulator and the one-deep result hold-back that lets the
  // final result of a word carry last.
  always_ff @(posedge clk) begin
    route_strobe <= 1'b0;
    s1_valid     <= (state == S_SCAN);
    s1_i         <= i;
    s1_self      <= (i == d);

    if (take) begin
      best <= sat;
      hop  <= s1_i;
      any  <= 1'b1;
    end

    case (state)
      S_CLEAR: begin
        clr <= clr + 1'b1;
        if (clr == {PA_BITS{1'b1}}) begin
          state <= S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op      <= opcode;
          nb      <= neighbor;
          cost_in <= cost;
          case (opcode)
            OP_LINK: begin
              d <= '0;
              if (nb_ok) begin
                state <= S_ROUTE_RD;
              end
            end
            OP_ADVERT: begin
              d <= dest;
              if (nb_ok && d_ok) begin
                state <= S_ROUTE_RD;
              end
            end
            OP_LOOKUP: begin
              d <= dest;
              if (d_ok) begin
                state <= S_LOOKUP_RD;
              end else begin
                // Out-of-table lookup: answer at once
                route_strobe <= 1'b1;
                route_dest   <= dest;
                route_cost   <= COST_MAX;
                next_hop     <= '0;
                found        <= 1'b0;
                last         <= 1'b1;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
      end
      S_ROUTE_RD: begin
        i     <= '0;
        best  <= COST_MAX;
        hop   <= '0;
        any   <= 1'b0;
        state <= S_SCAN;
      end
      S_SCAN: begin
        i <= i + 1'b1;
        if (i == NB'(NODES - 1)) begin
          state <= S_DRAIN;
        end
      end
      S_DRAIN: begin
        state <= S_DECIDE;
      end
      S_DECIDE: begin
        if (upd) begin
          if (pend_valid) begin
            route_strobe <= 1'b1;
            route_dest   <= pend_dest;
            route_cost   <= pend_cost;
            next_hop     <= pend_hop;
            found        <= 1'b1;
            last         <= 1'b0;
          end
          pend_valid <= 1'b1;
          pend_dest  <= d;
          pend_cost  <= best;
          pend_hop   <= hop;
        end
        if (op == OP_LINK) begin
          if (d == NB'(NODES - 1)) begin
            state <= S_CREATE_RD;
          end else begin
            d     <= d + 1'b1;
            state <= S_ROUTE_RD;
          end
        end else begin
          state <= S_FINISH;
        end
      end
      S_CREATE_RD: begin
        state <= S_CREATE;
      end
      S_CREATE: begin
        if (create) begin
          if (pend_valid) begin
            route_strobe <= 1'b1;
            route_dest   <= pend_dest;
            route_cost   <= pend_cost;
            next_hop     <= pend_hop;
            found        <= 1'b1;
            last         <= 1'b0;
          end
          pend_valid <= 1'b1;
          pend_dest  <= nb;
          pend_cost  <= cost_in;
          pend_hop   <= nb;
        end
        state <= S_FINISH;
      end
      S_LOOKUP_RD: begin
        state <= S_LOOKUP_OUT;
      end
      S_LOOKUP_OUT: begin
        route_strobe <= 1'b1;
        route_dest   <= d;
        route_cost   <= r_valid ? r_cost : COST_MAX;
        next_hop     <= r_valid ? r_hop : '0;
        found        <= r_valid;
        last         <= 1'b1;
        state        <= S_IDLE;
      end
      S_FINISH: begin
        // Release the held result as the last of this word
        if (pend_valid) begin
          route_strobe <= 1'b1;
          route_dest   <= pend_dest;
          route_cost   <= pend_cost;
          next_hop     <= pend_hop;
          found        <= 1'b1;
          last         <= 1'b1;
        end
        pend_valid <= 1'b0;
        state      <= S_IDLE;
      end
      default: begin
        state <= S_IDLE;
      end
    endcase

    if (rst) begin
      state        <= S_CLEAR;
      clr          <= '0;
      pend_valid   <= 1'b0;
      route_strobe <= 1'b0;
      s1_valid     <= 1'b0;
      any          <= 1'b0;
    end
  end

endmodule

### sv/dvrt_checker.sv
// Port-level checks of the route table, bound to the top level.
`include "distance_vector_route_table_core_macros.svh"

module dvrt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic [dvrt_pkg::OP_BITS-1:0] opcode,
  input logic                         route_strobe,
  input logic                         found,
  input logic                         last
);
  import dvrt_pkg::*;

  `DVRT_ASSERT_NEXT(a_rsvd_silent, start && !busy && (opcode == OP_RSVD), !route_strobe)
  `DVRT_ASSERT_NOW(a_miss_is_last, route_strobe && !found, last)
  `DVRT_ASSERT_NOW(a_more_keeps_busy, route_strobe && !last, busy)
  `DVRT_ASSERT_NOW(a_idle_result_last, route_strobe && !busy, last)

endmodule

bind distance_vector_route_table_core dvrt_checker u_dvrt_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .opcode       (opcode),
  .route_strobe (route_strobe),
  .found        (found),
  .last         (last)
);

### test/distance_vector_route_table_core_tb.sv
// Self-checking testbench for the distance-vector route table core.
module distance_vector_route_table_core_tb;
  import dvrt_pkg::*;

  localparam int NODES     = 16;
  localparam logic [15:0] UNREACH = 16'hFFFF;
  localparam int STALL_LIMIT = 4000;  // covers the clear sweep plus a full link update
  localparam int TAIL_CYCLES = 400;
  localparam int RAND_WORDS  = 130;

  typedef struct packed {
    logic [3:0]  dest;
    logic [15:0] cost;
    logic [3:0]  hop;
    logic        found;
    logic        last;
  } route_t;

  typedef struct {
    logic [1:0]  op;
    logic [3:0]  nb;
    logic [3:0]  d;
    logic [15:0] c;
    bit          typed;   // expected lookup answer given in the row
    logic [15:0] t_cost;
    logic [3:0]  t_hop;
    logic        t_found;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode = '0;
  logic [3:0]  neighbor = '0;
  logic [3:0]  dest = '0;
  logic [15:0] cost = '0;
  logic        route_strobe;
  logic [3:0]  route_dest;
  logic [15:0] route_cost;
  logic [3:0]  next_hop;
  logic        found;
  logic        last;

  // shadow of the table
  logic [15:0] lnk_cost [NODES];
  bit          lnk_ok   [NODES];
  logic [15:0] adv_cost [NODES*NODES];
  bit          adv_ok   [NODES*NODES];
  logic [15:0] route_best [NODES];
  logic [3:0]  route_via  [NODES];
  bit          route_ok   [NODES];

  route_t pending_routes[$];
  int     errors = 0;
  int     quiet_cycles = 0;
  bit     row_typed = 0;
  route_t row_answer;

  distance_vector_route_table_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .neighbor(neighbor), .dest(dest), .cost(cost),
    .route_strobe(route_strobe), .route_dest(route_dest), .route_cost(route_cost),
    .next_hop(next_hop), .found(found), .last(last)
  );

  always #10 clk = ~clk;

  // Append one expected route to the tail of the queue.
  function automatic void add_expected(route_t r);
    pending_routes.insert(pending_routes.size(), r);
  endfunction

  // Re-run Bellman-Ford for one destination; return 1 when its cost moves.
  function automatic bit refresh_route(int d);
    logic [16:0] sum;
    logic [15:0] best;
    logic [3:0]  via;
    bit          any;
    best = UNREACH;
    via  = '0;
    any  = 0;
    for (int i = 0; i < NODES; i++) begin
      if (!lnk_ok[i]) continue;
      if (i == d) sum = {1'b0, lnk_cost[i]};
      else if (adv_ok[i*NODES+d]) sum = lnk_cost[i] + adv_cost[i*NODES+d];
      else continue;
      if (sum > UNREACH) sum = UNREACH;
      if (!any || sum[15:0] < best) begin
        best = sum[15:0];
        via  = i[3:0];
        any  = 1;
      end
    end
    if (best != route_best[d]) begin
      route_best[d] = best;
      route_via[d]  = via;
      route_ok[d]   = 1;
      return 1;
    end
    return 0;
  endfunction

  // Apply one word to the shadow table and queue the routes it should emit.
  task automatic predict_routes(logic [1:0] op, logic [3:0] nb, logic [3:0] d,
                                logic [15:0] c);
    route_t r;
    int     first;
    first = pending_routes.size();
    case (op)
      OP_LOOKUP: begin
        r.dest  = d;
        r.cost  = route_ok[d] ? route_best[d] : UNREACH;
        r.hop   = route_ok[d] ? route_via[d] : 4'd0;
        r.found = route_ok[d];
        r.last  = 1'b1;
        add_expected(r);
      end
      OP_LINK: begin
        lnk_cost[nb] = c;
        lnk_ok[nb]   = 1;
        for (int i = 0; i < NODES; i++) begin
          if (route_ok[i] && refresh_route(i)) begin
            r = '{dest: i[3:0], cost: route_best[i], hop: route_via[i], found: 1'b1,
                  last: 1'b0};
            add_expected(r);
          end
        end
        if (!route_ok[nb]) begin
          route_ok[nb]   = 1;
          route_best[nb] = c;
          route_via[nb]  = nb;
          add_expected('{dest: nb, cost: c, hop: nb, found: 1'b1, last: 1'b0});
        end
      end
      OP_ADVERT: begin
        adv_cost[nb*NODES+d] = c;
        adv_ok[nb*NODES+d]   = 1;
        if (refresh_route(d))
          add_expected('{dest: d, cost: route_best[d], hop: route_via[d],
                         found: 1'b1, last: 1'b0});
      end
      default: ;  // reserved opcode: drop
    endcase
    if (pending_routes.size() > first)
      pending_routes[pending_routes.size()-1].last = 1'b1;
  endtask

  // Check emitted routes first, then record any word taken at this edge.
  always @(posedge clk) begin
    if (!rst) begin
      quiet_cycles = quiet_cycles + 1;
      if (route_strobe) begin
        quiet_cycles = 0;
        if (pending_routes.size() == 0) begin
          $display("%0t: unexpected route dest=%0d cost=%0d hop=%0d found=%0b last=%0b",
                   $time, route_dest, route_cost, next_hop, found, last);
          errors++;
        end else begin
          route_t e;
          e = pending_routes.pop_front();
          if (route_dest !== e.dest || route_cost !== e.cost || next_hop !== e.hop ||
              found !== e.found || last !== e.last) begin
            $display("%0t: mismatch exp dest=%0d cost=%0d hop=%0d found=%0b last=%0b",
                     $time, e.dest, e.cost, e.hop, e.found, e.last);
            $display("%0t:          got dest=%0d cost=%0d hop=%0d found=%0b last=%0b",
                     $time, route_dest, route_cost, next_hop, found, last);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        quiet_cycles = 0;
        predict_routes(opcode, neighbor, dest, cost);
        // a typed answer in the row stands in for the predicted lookup
        if (row_typed) pending_routes[pending_routes.size()-1] = row_answer;
      end
      if (quiet_cycles > STALL_LIMIT) begin
        $display("[distance_vector_route_table_core] ERROR");
        $finish;
      end
    end
  end

  // Present one word and hold it until taken; then idle now and again.
  task automatic send_word(logic [1:0] op, logic [3:0] nb, logic [3:0] d, logic [15:0] c,
                           bit may_idle);
    start    <= 1'b1;
    opcode   <= op;
    neighbor <= nb;
    dest     <= d;
    cost     <= c;
    do @(posedge clk); while (busy);
    if (may_idle && $urandom_range(0, 99) < 32) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain_routes();
    start <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_cost();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return UNREACH;
      2: return 16'(UNREACH - $urandom_range(0, 40));
      3: return 16'($urandom);
      default: return 16'($urandom_range(0, 200));
    endcase
  endfunction

  row_t rows[$];

  initial begin
    logic [1:0] op;
    int         pick;
    for (int i = 0; i < NODES; i++) begin
      lnk_cost[i] = '0; lnk_ok[i] = 0;
      route_best[i] = UNREACH; route_via[i] = '0; route_ok[i] = 0;
    end
    for (int i = 0; i < NODES*NODES; i++) begin
      adv_cost[i] = '0; adv_ok[i] = 0;
    end

    // the early lookups carry typed answers; the other rows rely on the predictor
    rows = '{
      '{OP_LOOKUP, 4'd0,  4'd0,  16'd0,     1, UNREACH, 4'd0, 1'b0}, // empty table
      '{OP_LOOKUP, 4'd0,  4'd15, 16'hFFFF,  1, UNREACH, 4'd0, 1'b0},
      '{OP_LINK,   4'd3,  4'd0,  16'd10,    0, '0, '0, '0},          // new direct route
      '{OP_LOOKUP, 4'd0,  4'd3,  16'd0,     1, 16'd10, 4'd3, 1'b1},
      '{OP_LINK,   4'd15, 4'd15, UNREACH,   0, '0, '0, '0},          // link at full cost
      '{OP_ADVERT, 4'd3,  4'd7,  16'd5,     0, '0, '0, '0},
      '{OP_LOOKUP, 4'd0,  4'd7,  16'd0,     1, 16'd15, 4'd3, 1'b1},
      '{OP_ADVERT, 4'd15, 4'd7,  UNREACH,   0, '0, '0, '0},          // saturating sum
      '{OP_ADVERT, 4'd3,  4'd9,  UNREACH,   0, '0, '0, '0},          // absent, stays unreachable
      '{OP_LOOKUP, 4'd0,  4'd9,  16'd0,     1, UNREACH, 4'd0, 1'b0},
      '{OP_ADVERT, 4'd4,  4'd9,  16'd1,     0, '0, '0, '0},          // neighbour not linked
      '{OP_RSVD,   4'd15, 4'd15, 16'hFFFF,  0, '0, '0, '0},          // dropped
      '{OP_LINK,   4'd0,  4'd0,  16'd0,     0, '0, '0, '0},
      '{OP_ADVERT, 4'd0,  4'd7,  16'd15,    0, '0, '0, '0},          // tie keeps the present hop
      '{OP_ADVERT, 4'd0,  4'd7,  16'd14,    0, '0, '0, '0},
      '{OP_LINK,   4'd3,  4'd0,  16'd0,     0, '0, '0, '0},          // routes 3 and 7 move
      '{OP_LINK,   4'd0,  4'd0,  UNREACH,   0, '0, '0, '0},
      '{OP_ADVERT, 4'd15, 4'd3,  16'd0,     0, '0, '0, '0},
      '{OP_LINK,   4'd3,  4'd3,  16'd10,    0, '0, '0, '0},          // cost rises again, routes 3 and 7 move
      '{OP_LOOKUP, 4'd0,  4'd7,  16'd0,     0, '0, '0, '0},
      '{OP_LOOKUP, 4'd0,  4'd15, 16'd0,     0, '0, '0, '0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      row_typed  <= rows[i].typed;
      row_answer <= '{dest: rows[i].d, cost: rows[i].t_cost, hop: rows[i].t_hop,
                      found: rows[i].t_found, last: 1'b1};
      send_word(rows[i].op, rows[i].nb, rows[i].d, rows[i].c, 1);
    end
    row_typed <= 1'b0;
    drain_routes();  // hold off until every route of the table has come

    for (int n = 0; n < RAND_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25)      op = OP_LINK;
      else if (pick < 70) op = OP_ADVERT;
      else if (pick < 95) op = OP_LOOKUP;
      else                op = OP_RSVD;
      if (n == 75) drain_routes();
      // no idling through the middle stretch
      send_word(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), pick_cost(),
                !(n >= 40 && n < 90));
    end
    start <= 1'b0;

    while (pending_routes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[distance_vector_route_table_core] OK");
    else
      $display("[distance_vector_route_table_core] ERROR");
    $finish;
  end
endmodule
